// ===== hw/rtl/wcls_pkg.sv =====
// Shared types, character constants and helpers for the command-line splitter.
package wcls_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END_ARG = 2'd1,
    KIND_END_LINE = 2'd2
  } kind_t;

  // Character codes the parser reacts to.
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // Most results one item can cause.
  localparam int unsigned MAX_RESULTS = 3;

  // One result item without its last flag.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [15:0] repeat_res;
  } result_t;

  // All results of one item and how many of them are valid.
  typedef struct packed {
    logic [1:0]                    cnt;
    result_t [MAX_RESULTS-1:0]     res;
  } group_t;

  // Parser state carried from item to item.
  typedef struct packed {
    logic        inside_argument;
    logic        quoted;
    logic [15:0] slash_run;
    logic [1:0]  trail_left;
  } state_t;

  localparam state_t STATE_RESET = '{1'b0, 1'b0, 16'd0, 2'd0};

  // Number of UTF-8 trailing bytes that follow a lead byte.
  function automatic logic [1:0] trail_count(input logic [7:0] b);
    logic [1:0] n;
    case (b) inside
      [8'hC0:8'hDF]: n = 2'd1;
      [8'hE0:8'hEF]: n = 2'd2;
      [8'hF0:8'hF7]: n = 2'd3;
      default:       n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/wcls_in_if.sv =====
// Input channel: one command-line byte per item.
interface wcls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// ===== hw/rtl/wcls_out_if.sv =====
// Result channel: one parsed result per item.
interface wcls_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic [15:0] repeat_res;
  logic        last;

  modport source (output valid, output kind, output value, output repeat_res, output last,
                  input ready);
  modport sink   (input valid, input kind, input value, input repeat_res, input last,
                  output ready);
endinterface

// ===== hw/rtl/windows_command_line_splitter.sv =====
// Top level of the command-line splitter: input register, parser state and result buffer.
//
//   Channel   Dir  Payload                          Accepted when
//   in_ch     in   ch[7:0]                          valid && ready
//   out_res   out  kind, value, repeat_res, last    valid && ready
//
// A byte is registered on acceptance and parsed in the next cycle against the parser
// state; its results (0 to 3) move into the result buffer as a group, going out one per
// cycle while out_res is ready. Then, with at most one result per byte, the input
// runs at one byte per cycle; a byte with more results holds it until the last one leaves.
// Reset (synchronous, rst_n low) empties both registers and returns to skipping whitespace.
// A stalled out_res holds the buffer; the input register fills, passing result-free bytes.
module windows_command_line_splitter #(
  parameter int unsigned MAX_SLASH_RUN = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  wcls_in_if.sink     in_ch,
  wcls_out_if.source  out_res
);
  import wcls_pkg::*;

  logic       a_valid_r;
  logic [7:0] a_ch_r;
  state_t     st_r;
  state_t     st_nxt;
  group_t     grp;
  logic       grp_free;
  logic       a_take;
  logic       load;

  // The registered byte moves on when its results fit in the buffer.
  assign a_take      = a_valid_r && ((grp.cnt == 2'd0) || grp_free);
  assign load        = a_take && (grp.cnt != 2'd0);
  assign in_ch.ready = !a_valid_r || a_take;

  // Input register and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      st_r      <= STATE_RESET;
    end else begin
      if (in_ch.ready) begin
        a_valid_r <= in_ch.valid;
      end
      if (a_take) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_ch_r <= in_ch.ch;
    end
  end

  // Parse logic.
  wcls_step #(
    .MAX_RUN (16'(MAX_SLASH_RUN))
  ) u_step (
    .st     (st_r),
    .ch     (a_ch_r),
    .st_nxt (st_nxt),
    .grp    (grp)
  );

  // Result buffer.
  wcls_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .grp     (grp),
    .free    (grp_free),
    .out_res (out_res)
  );

endmodule

// ===== hw/rtl/wcls_step.sv =====
// Per-byte parse logic: next state and up to three results for one byte.
module wcls_step #(
  parameter logic [15:0] MAX_RUN = 16'hFFFF
) (
  input  wcls_pkg::state_t st,
  input  logic [7:0]       ch,
  output wcls_pkg::state_t st_nxt,
  output wcls_pkg::group_t grp
);
  import wcls_pkg::*;

  // Decode the byte against the current state and collect the results in order.
  always_comb begin
    logic [1:0]  n;
    logic        q;
    logic [15:0] s;
    logic        ws;
    n      = 2'd0;
    st_nxt = st;
    grp    = '0;
    q      = st.inside_argument ? st.quoted : 1'b0;
    s      = st.inside_argument ? st.slash_run : 16'd0;
    ws     = (ch == CH_SPACE) || (ch == CH_TAB);

    if (ch == CH_NUL) begin
      // End of line: flush the argument if one is open, then reset all state.
      if (st.inside_argument) begin
        if (st.slash_run != 16'd0) begin
          grp.res[n] = '{KIND_DATA, CH_BACKSLASH, st.slash_run};
          n = n + 2'd1;
        end
        grp.res[n] = '{KIND_END_ARG, 8'd0, 16'd1};
        n = n + 2'd1;
      end
      grp.res[n] = '{KIND_END_LINE, 8'd0, 16'd1};
      n = n + 2'd1;
      st_nxt = STATE_RESET;
    end else if (st.trail_left != 2'd0) begin
      // UTF-8 trailing byte is copied without interpretation.
      grp.res[n] = '{KIND_DATA, ch, 16'd1};
      n = n + 2'd1;
      st_nxt.trail_left = st.trail_left - 2'd1;
    end else if (!st.inside_argument && (ws || ch == CH_CR || ch == CH_LF)) begin
      // Whitespace between arguments is skipped.
      st_nxt = st;
    end else begin
      st_nxt.inside_argument = 1'b1;
      st_nxt.quoted          = q;
      st_nxt.slash_run       = 16'd0;
      if (ws) begin
        // Space or tab: data inside quotes, otherwise the argument ends.
        if (s != 16'd0) begin
          grp.res[n] = '{KIND_DATA, CH_BACKSLASH, s};
          n = n + 2'd1;
        end
        if (q) begin
          grp.res[n] = '{KIND_DATA, ch, 16'd1};
        end else begin
          grp.res[n] = '{KIND_END_ARG, 8'd0, 16'd1};
          st_nxt.inside_argument = 1'b0;
        end
        n = n + 2'd1;
      end else if (ch == CH_QUOTE) begin
        // Halve the held run; an even run toggles quoting, an odd one escapes the quote.
        if (s >= 16'd2) begin
          grp.res[n] = '{KIND_DATA, CH_BACKSLASH, {1'b0, s[15:1]}};
          n = n + 2'd1;
        end
        if (!s[0]) begin
          st_nxt.quoted = !q;
        end else begin
          grp.res[n] = '{KIND_DATA, CH_QUOTE, 16'd1};
          n = n + 2'd1;
        end
      end else if (ch == CH_BACKSLASH) begin
        // Count backslashes, saturating at the run limit.
        st_nxt.slash_run = (s < MAX_RUN) ? s + 16'd1 : s;
      end else begin
        // Ordinary byte: flush held backslashes, emit it, note UTF-8 trailers.
        if (s != 16'd0) begin
          grp.res[n] = '{KIND_DATA, CH_BACKSLASH, s};
          n = n + 2'd1;
        end
        grp.res[n] = '{KIND_DATA, ch, 16'd1};
        n = n + 2'd1;
        st_nxt.trail_left = trail_count(ch);
      end
    end
    grp.cnt = n;
  end

endmodule

// ===== hw/rtl/wcls_out_buf.sv =====
// Result register: holds one item's results and sends one per cycle while ready.
module wcls_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  wcls_pkg::group_t grp,
  output logic             free,
  wcls_out_if.source       out_res
);
  import wcls_pkg::*;

  logic       v_r;
  logic [1:0] idx_r;
  group_t     g_r;
  result_t    cur;
  logic       is_last;

  assign is_last = (idx_r == g_r.cnt - 2'd1);
  assign free    = !v_r || (out_res.ready && is_last);

  // Walk through the held results; a new group may load as the last one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      idx_r <= 2'd0;
    end else if (load) begin
      v_r   <= 1'b1;
      idx_r <= 2'd0;
    end else if (v_r && out_res.ready) begin
      if (is_last) begin
        v_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      g_r <= grp;
    end
  end

  // Present the current result.
  assign cur                = g_r.res[idx_r];
  assign out_res.valid      = v_r;
  assign out_res.kind       = cur.kind;
  assign out_res.value      = cur.value;
  assign out_res.repeat_res = cur.repeat_res;
  assign out_res.last       = is_last;

endmodule
